// File: design/fdm_pkg.sv
`timescale 1ns / 1ps

package fdm_pkg;

  localparam int TABLE_ENTRIES_DEF = 64;
  localparam int PID_BITS_DEF      = 16;
  localparam int HOST_FD_BITS_DEF  = 16;

  localparam int KFD_BITS  = 6;
  localparam int KFD_SPACE = 1 << KFD_BITS;

  localparam int PID_IN_BITS  = 16;
  localparam int HOST_IN_BITS = 16;

  localparam logic [1:0] OP_ALLOC  = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;
  localparam logic [1:0] OP_DELETE = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_EXISTS   = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

endpackage

// File: design/fdm_ram.sv
`timescale 1ns / 1ps

module fdm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/fd_map_table.sv
`timescale 1ns / 1ps

// Descriptor mapping table. Each input transfer on the s_axis side carries one
// operation (allocate lowest free, insert, lookup, delete); each produces exactly
// one result transfer on the m_axis side with a status, the granted kernel
// descriptor and the host descriptor found by a lookup.
// The table lives in one synchronous RAM holding valid bit, process, kernel
// descriptor and host descriptor per slot. Every operation reads all
// TABLE_ENTRIES slots, one per cycle, then decides in a finish step and writes
// back any changed slot. The result is loaded into the output register when
// the finish step advances, and only then is the next item accepted, so the
// block takes no new item until the scan of the last one is through, a limit
// set by the single read port of the table RAM.
// After reset the block clears every slot in turn, during which
// s_axis_tready stays low.
// A finished result waits in an output register; the next item is accepted and
// scanned meanwhile. If the receiver still stalls when that next result is ready,
// the block holds it, and accepts nothing further, until the waiting transfer is
// taken.
module fd_map_table
  import fdm_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int PID_BITS      = PID_BITS_DEF,
  parameter int HOST_FD_BITS  = HOST_FD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // opcode [1:0], process_id [17:2], host_descriptor [33:18],
  // kernel_descriptor [39:34]
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status [1:0], granted_descriptor [7:2], found_host [23:8]
  output logic [23:0] m_axis_tdata
);

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int EW = 1 + HOST_FD_BITS + KFD_BITS + PID_BITS;
  localparam logic [AW-1:0] LAST = AW'(TABLE_ENTRIES - 1);

  localparam logic [1:0] S_CLEAR  = 2'd0;
  localparam logic [1:0] S_IDLE   = 2'd1;
  localparam logic [1:0] S_SCAN   = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0] state;

  logic [AW-1:0] clr_addr;
  logic [AW-1:0] scan_addr;
  logic          issuing;
  logic          chk_en;
  logic          chk_last;
  logic [AW-1:0] chk_addr;

  logic [1:0]              op;
  logic [PID_BITS-1:0]     pid;
  logic [HOST_FD_BITS-1:0] host;
  logic [KFD_BITS-1:0]     kfd;

  logic                    found;
  logic [AW-1:0]           found_slot;
  logic [HOST_FD_BITS-1:0] found_hfd;
  logic                    free_found;
  logic [AW-1:0]           free_slot;
  logic [KFD_SPACE-1:0]    used;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic [EW-1:0] ram_rdata;

  logic                    rd_valid;
  logic [HOST_FD_BITS-1:0] rd_host;
  logic [KFD_BITS-1:0]     rd_kfd;
  logic [PID_BITS-1:0]     rd_pid;
  logic                    pid_hit;
  logic                    pair_hit;
  logic                    match_hit;

  logic [KFD_SPACE:0]  inc;
  logic [KFD_SPACE:0]  iso;
  logic [KFD_BITS-1:0] low_free;

  logic                advance;
  logic                fin_we;
  logic [AW-1:0]       fin_addr;
  logic [EW-1:0]       fin_wdata;
  logic [1:0]          res_status;
  logic [KFD_BITS-1:0] res_granted;
  logic [15:0]         res_found;

  logic        out_valid;
  logic [23:0] out_data;

  fdm_ram #(
    .WIDTH(EW),
    .DEPTH(TABLE_ENTRIES)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (issuing),
    .raddr(scan_addr),
    .rdata(ram_rdata)
  );

  assign rd_valid = ram_rdata[EW-1];
  assign rd_host  = ram_rdata[EW-2 -: HOST_FD_BITS];
  assign rd_kfd   = ram_rdata[PID_BITS +: KFD_BITS];
  assign rd_pid   = ram_rdata[PID_BITS-1:0];

  assign pid_hit   = rd_valid && (rd_pid == pid);
  assign pair_hit  = pid_hit && (rd_kfd == kfd);
  assign match_hit = (op == OP_DELETE) ? (pair_hit && (rd_host == host)) : pair_hit;

  assign s_axis_tready = (state == S_IDLE);
  assign advance       = (state == S_FINISH) && (!out_valid || m_axis_tready);

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  // Lowest clear bit of the used mask, isolated as a one-hot word.
  assign inc = {1'b0, used} + {{KFD_SPACE{1'b0}}, 1'b1};
  assign iso = ~{1'b0, used} & inc;

  always_comb begin
    low_free = '0;
    for (int b = 0; b < KFD_BITS; b++) begin
      for (int j = 0; j < KFD_SPACE; j++) begin
        if (((j >> b) & 1) == 1) begin
          low_free[b] = low_free[b] | iso[j];
        end
      end
    end
  end

  always_comb begin
    fin_we      = 1'b0;
    fin_addr    = free_slot;
    fin_wdata   = {1'b1, host, kfd, pid};
    res_status  = ST_OK;
    res_granted = '0;
    res_found   = '0;
    case (op)
      OP_ALLOC: begin
        if (iso[KFD_SPACE] || !free_found) begin
          res_status = ST_FULL;
        end else begin
          fin_we      = 1'b1;
          fin_wdata   = {1'b1, host, low_free, pid};
          res_granted = low_free;
        end
      end
      OP_INSERT: begin
        if (found) begin
          res_status = ST_EXISTS;
        end else if (!free_found) begin
          res_status = ST_FULL;
        end else begin
          fin_we      = 1'b1;
          res_granted = kfd;
        end
      end
      OP_LOOKUP: begin
        if (found) begin
          res_found = 16'(found_hfd);
        end else begin
          res_status = ST_NOTFOUND;
        end
      end
      default: begin
        if (found) begin
          fin_we    = 1'b1;
          fin_addr  = found_slot;
          fin_wdata = '0;
        end else begin
          res_status = ST_NOTFOUND;
        end
      end
    endcase
  end

  always_comb begin
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = advance && fin_we;
      ram_waddr = fin_addr;
      ram_wdata = fin_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      scan_addr <= '0;
      issuing   <= 1'b0;
      chk_en    <= 1'b0;
      chk_last  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      chk_en   <= issuing;
      chk_last <= issuing && (scan_addr == LAST);
      chk_addr <= scan_addr;
      if (out_valid && m_axis_tready && !advance) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_axis_tvalid) begin
            op         <= s_axis_tdata[1:0];
            pid        <= PID_BITS'(s_axis_tdata[17:2]);
            host       <= HOST_FD_BITS'(s_axis_tdata[33:18]);
            kfd        <= s_axis_tdata[39:34];
            found      <= 1'b0;
            free_found <= 1'b0;
            used       <= '0;
            scan_addr  <= '0;
            issuing    <= 1'b1;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (issuing) begin
            scan_addr <= scan_addr + AW'(1);
            if (scan_addr == LAST) begin
              issuing <= 1'b0;
            end
          end
          if (chk_en) begin
            if (pid_hit) begin
              used[rd_kfd] <= 1'b1;
            end
            if (match_hit && !found) begin
              found      <= 1'b1;
              found_slot <= chk_addr;
              found_hfd  <= rd_host;
            end
            if (!rd_valid && !free_found) begin
              free_found <= 1'b1;
              free_slot  <= chk_addr;
            end
            if (chk_last) begin
              state <= S_FINISH;
            end
          end
        end
        default: begin
          if (advance) begin
            out_valid <= 1'b1;
            out_data  <= {res_found, res_granted, res_status};
            state     <= S_IDLE;
          end
        end
      endcase
    end
  end

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> !ram_we)
    else $error("table written during a scan");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_FINISH))
    else $error("result loaded outside the finish step");

  a_check_in_scan: assert property (@(posedge clk) disable iff (rst)
    chk_en |-> (state == S_SCAN))
    else $error("read data checked outside a scan");

  a_refused_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_data[1:0] != ST_OK)) |-> (out_data[23:2] == '0))
    else $error("refused operation carries a descriptor");

  a_idle_no_reads: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (!issuing && !chk_en))
    else $error("table read while idle");

endmodule
